// ----- hdl/rbrc_pkg.sv -----
// Shared types and constants for the random byte ring cache.
`timescale 1ns / 1ps
package rbrc_pkg;

	localparam int RING_BYTES_DEF = 64;
	localparam int MAX_READ_DEF   = 32;

	localparam int SHIFT_BYTE = 8;

	localparam logic ACT_WORD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] random_word;
		logic        word_ready;
		logic [5:0]  read_size;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic [5:0] bytes_returned;
		logic       last;
		logic       generator_on;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_RD_ISSUE,
		ST_RD_LOAD,
		ST_RD_EMPTY
	} state_t;

endpackage

// ----- hdl/rbrc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module rbrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/random_byte_ring_cache.sv -----
// Top level of the random byte ring cache: ring control around one byte RAM.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_valid, in_stall, in_data) carries two kinds of transfer.
// A word arrival (action = word) is taken only while the generator is on and
// word_ready is set; its four bytes are written most significant first, one per
// cycle, and the block is busy while it writes them and gives no result. When
// the ring comes within one slot of the read pointer, the generator turns off
// and the rest of the word is dropped.
// A read request returns min(read_size, MAX_READ, bytes held) results on the
// output channel (out_valid, out_stall, out_data). Each byte is a RAM read in
// ST_RD_ISSUE followed by a load of the output register in ST_RD_LOAD, and
// the next byte is not read before that load. An empty read gives one result
// with byte_valid clear and last set.
// A stalled output holds its result, and the read sequencer waits until the
// output register is free; in_stall stays high until the last byte is loaded.
// Reset clears the ring pointers and the output valid and turns the generator
// on; the RAM contents are not cleared and are only read once written.
module random_byte_ring_cache #(
	parameter int RING_BYTES = rbrc_pkg::RING_BYTES_DEF,
	parameter int MAX_READ   = rbrc_pkg::MAX_READ_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rbrc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output rbrc_pkg::out_item_t out_data
);

	import rbrc_pkg::*;

	localparam int IW = $clog2(RING_BYTES);
	localparam int CW = $clog2(MAX_READ + 1);
	localparam int SW0 = (IW > CW) ? IW : CW;
	localparam int SW = (SW0 > 6) ? SW0 : 6;
	localparam logic [IW-1:0] RING_LAST = IW'(RING_BYTES - 1);

	function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] x);
		ring_inc = (x == RING_LAST) ? '0 : x + 1'b1;
	endfunction

	state_t state_q, state_nx;

	logic [IW-1:0] wr_idx_q, rd_idx_q;
	logic          gen_on_q;
	logic [31:0]   word_q;
	logic [1:0]    byte_cnt_q;
	logic [CW-1:0] rd_total_q, rd_left_q;

	logic          out_valid_q;
	out_item_t     out_q;

	logic          ram_we, ram_re, load_byte, load_empty, out_free;
	logic [7:0]    ram_rdata;
	logic [IW-1:0] wr_next;
	logic          ring_full;

	logic          accept;
	logic [IW:0]   avail_wide;
	logic [IW-1:0] avail;
	logic [SW-1:0] req_w, avail_w, n_w;
	logic [CW-1:0] n_new;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Bytes held between the read and write pointers, modulo the ring size.
	always_comb begin
		avail_wide = {1'b0, wr_idx_q} - {1'b0, rd_idx_q};
		if (wr_idx_q < rd_idx_q) begin
			avail_wide = avail_wide + (IW + 1)'(RING_BYTES);
		end
		avail   = avail_wide[IW-1:0];
		avail_w = SW'(avail);
		req_w   = (SW'(in_data.read_size) > SW'(MAX_READ)) ? SW'(MAX_READ)
		                                                    : SW'(in_data.read_size);
		n_w     = (req_w < avail_w) ? req_w : avail_w;
		n_new   = CW'(n_w);
	end

	assign wr_next   = ring_inc(wr_idx_q);
	assign ring_full = (ring_inc(wr_next) == rd_idx_q);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.action == ACT_READ) begin
						state_nx = (n_new == '0) ? ST_RD_EMPTY : ST_RD_ISSUE;
					end else if (gen_on_q && in_data.word_ready) begin
						state_nx = ST_WRITE;
					end
				end
			end
			ST_WRITE: begin
				if (ring_full || byte_cnt_q == 2'd3) begin
					state_nx = ST_IDLE;
				end
			end
			ST_RD_ISSUE: begin
				if (out_free) begin
					state_nx = ST_RD_LOAD;
				end
			end
			ST_RD_LOAD: begin
				state_nx = (rd_left_q == '0) ? ST_IDLE : ST_RD_ISSUE;
			end
			ST_RD_EMPTY: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		load_byte  = 1'b0;
		load_empty = 1'b0;
		case (state_q)
			ST_WRITE:    ram_we     = 1'b1;
			ST_RD_ISSUE: ram_re     = out_free;
			ST_RD_LOAD:  load_byte  = 1'b1;
			ST_RD_EMPTY: load_empty = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			gen_on_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE && accept && in_data.action == ACT_READ && n_new != '0) begin
				gen_on_q <= 1'b1;
			end
			if (ram_we) begin
				wr_idx_q <= wr_next;
				if (ring_full) begin
					gen_on_q <= 1'b0;
				end
			end
			if (ram_re) begin
				rd_idx_q <= ring_inc(rd_idx_q);
			end
			if (load_byte || load_empty) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			word_q     <= in_data.random_word;
			byte_cnt_q <= '0;
			rd_total_q <= n_new;
			rd_left_q  <= n_new;
		end
		if (ram_we) begin
			word_q     <= word_q << SHIFT_BYTE;
			byte_cnt_q <= byte_cnt_q + 1'b1;
		end
		if (ram_re) begin
			rd_left_q <= rd_left_q - 1'b1;
		end
		if (load_byte) begin
			out_q.data_byte      <= ram_rdata;
			out_q.byte_valid     <= 1'b1;
			out_q.bytes_returned <= 6'(rd_total_q);
			out_q.last           <= (rd_left_q == '0);
			out_q.generator_on   <= 1'b1;
		end else if (load_empty) begin
			out_q.data_byte      <= '0;
			out_q.byte_valid     <= 1'b0;
			out_q.bytes_returned <= '0;
			out_q.last           <= 1'b1;
			out_q.generator_on   <= gen_on_q;
		end
	end

	rbrc_ram #(
		.WIDTH(8),
		.DEPTH(RING_BYTES)
	) ring_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx_q),
		.wdata(word_q[31:24]),
		.re   (ram_re),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hdl/rbrc_chk.sv -----
// Port-level checker for the random byte ring cache, bound to the top level.
`timescale 1ns / 1ps
module rbrc_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input rbrc_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input rbrc_pkg::out_item_t out_data
);

	import rbrc_pkg::*;

	// A stalled result stays put until it is transferred.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// An empty read result is a single, final, zero result.
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.byte_valid |->
			out_data.last && out_data.bytes_returned == 6'd0 && out_data.data_byte == 8'd0)
		else $error("malformed empty read result");

	// Any returned byte means the generator has been turned back on.
	a_byte_gen_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.byte_valid |-> out_data.generator_on)
		else $error("byte returned with generator off");

	// A read request always makes the block busy once it is taken.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.action == ACT_READ |=> in_stall)
		else $error("read request did not occupy the block");

endmodule

bind random_byte_ring_cache rbrc_chk chk_i (.*);

// ----- verif/random_byte_ring_cache_checker.sv -----
// Checker for the random byte ring cache: predicts every returned byte and compares each transfer.
`timescale 1ns / 1ps
module random_byte_ring_cache_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  rbrc_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  rbrc_pkg::out_item_t out_data,
	output int                  mismatch_count,
	output int                  bytes_owed
);

	import rbrc_pkg::*;

	localparam int PTR_W = $clog2(RING_BYTES_DEF);

	logic [7:0]       ring_copy [RING_BYTES_DEF];
	logic [PTR_W-1:0] wr_ptr;
	logic [PTR_W-1:0] rd_ptr;
	logic [PTR_W-1:0] next_wr;
	logic [PTR_W-1:0] held;
	bit               gen_on;
	bit               word_cut;
	out_item_t        expected_bytes [$];
	out_item_t        want;
	out_item_t        guess;
	in_item_t         seen;
	int unsigned      req;
	int unsigned      count;
	int               fails;

	task automatic compare_field(input string name, input int unsigned exp_val,
			input int unsigned act_val, input bit is_x);
		if (is_x || exp_val != act_val) begin
			$error("%s: expected %0h, actual %0h", name, exp_val, act_val);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr = '0;
			rd_ptr = '0;
			gen_on = 1'b1;
			fails = 0;
			expected_bytes.delete();
			mismatch_count <= 0;
			bytes_owed <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("result transfer with nothing expected: data_byte %0h last %0b",
						out_data.data_byte, out_data.last);
					fails++;
				end else begin
					want = expected_bytes.pop_front();
					compare_field("data_byte", want.data_byte, out_data.data_byte,
						$isunknown(out_data.data_byte));
					compare_field("byte_valid", want.byte_valid, out_data.byte_valid,
						$isunknown(out_data.byte_valid));
					compare_field("bytes_returned", want.bytes_returned,
						out_data.bytes_returned, $isunknown(out_data.bytes_returned));
					compare_field("last", want.last, out_data.last,
						$isunknown(out_data.last));
					compare_field("generator_on", want.generator_on, out_data.generator_on,
						$isunknown(out_data.generator_on));
				end
			end

			if (in_valid && !in_stall) begin
				seen = in_data;
				if (seen.action == ACT_WORD) begin
					// Bytes go in most significant first; the ring stops one slot
					// short of the read pointer and drops the rest of the word.
					if (gen_on && seen.word_ready) begin
						word_cut = 1'b0;
						for (int k = 0; k < 4; k++) begin
							if (!word_cut) begin
								ring_copy[wr_ptr] = seen.random_word[8 * (3 - k) +: 8];
								wr_ptr = wr_ptr + 1'b1;
								next_wr = wr_ptr + 1'b1;
								if (next_wr == rd_ptr) begin
									gen_on = 1'b0;
									word_cut = 1'b1;
								end
							end
						end
					end
				end else begin
					req = (seen.read_size > MAX_READ_DEF) ? MAX_READ_DEF : seen.read_size;
					held = wr_ptr - rd_ptr;
					count = (req < held) ? req : held;
					if (count == 0) begin
						guess = '0;
						guess.last = 1'b1;
						guess.generator_on = gen_on;
						expected_bytes.push_back(guess);
					end else begin
						gen_on = 1'b1;
						for (int unsigned i = 0; i < count; i++) begin
							guess.data_byte = ring_copy[rd_ptr];
							guess.byte_valid = 1'b1;
							guess.bytes_returned = count[5:0];
							guess.last = (i + 1 == count);
							guess.generator_on = 1'b1;
							expected_bytes.push_back(guess);
							rd_ptr = rd_ptr + 1'b1;
						end
					end
				end
			end

			mismatch_count <= fails;
			bytes_owed <= expected_bytes.size();
		end
	end

endmodule

// ----- verif/random_byte_ring_cache_tb.sv -----
// Testbench top for the random byte ring cache: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module random_byte_ring_cache_tb;
	import rbrc_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	int        mismatch_count;
	int        bytes_owed;
	bit        steady = 1'b0;

	random_byte_ring_cache i_dut (.*);

	random_byte_ring_cache_checker i_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 23);
	end

	task automatic offer(input logic act, input logic [31:0] word, input logic rdy,
			input logic [5:0] size);
		in_item_t item;
		item.action = act;
		item.random_word = word;
		item.word_ready = rdy;
		item.read_size = size;
		if (!steady && $urandom_range(0, 99) < 23) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// The owed count is registered and so lags the transfers; look at it only
	// once the last transfer has reached that register.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bytes_owed != 0) @(posedge clk);
	endtask

	initial begin
		int  pick;
		int  burst;
		int  sent;
		bit  paused;
		logic [5:0] size;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty ring, a dropped word, both all-ones and all-zeros words.
		offer(ACT_READ, $urandom, 1'b1, 6'd0);
		offer(ACT_READ, $urandom, 1'b0, 6'd63);
		offer(ACT_WORD, 32'hdeadbeef, 1'b0, 6'd5);
		offer(ACT_WORD, 32'hffffffff, 1'b1, 6'd63);
		offer(ACT_WORD, 32'h00000000, 1'b1, 6'd0);
		offer(ACT_READ, 32'h0, 1'b1, 6'd1);
		offer(ACT_READ, 32'hffffffff, 1'b0, 6'd40);
		// Fill until the generator shuts off mid-word, then one word while off.
		repeat (17) offer(ACT_WORD, $urandom, 1'b1, 6'($urandom_range(0, 63)));
		offer(ACT_READ, $urandom, 1'b1, 6'd0);
		offer(ACT_READ, $urandom, 1'b1, 6'd33);
		offer(ACT_READ, $urandom, 1'b0, 6'd32);
		drain();
		repeat (8) @(posedge clk);

		sent = 0;
		paused = 1'b0;
		while (sent < 385) begin
			steady = (sent >= 150 && sent < 230);
			if (!paused && sent >= 300) begin
				drain();
				repeat (8) @(posedge clk);
				paused = 1'b1;
			end
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				burst = $urandom_range(8, 18);
				repeat (burst) offer(ACT_WORD, $urandom, 1'b1, 6'($urandom_range(0, 63)));
				sent += burst;
			end else if (pick < 6) begin
				offer(ACT_WORD, $urandom, $urandom_range(0, 9) != 0,
					6'($urandom_range(0, 63)));
				sent++;
			end else begin
				case ($urandom_range(0, 9))
					0: size = 6'd0;
					1: size = 6'($urandom_range(33, 63));
					default: size = 6'($urandom_range(1, 32));
				endcase
				offer(ACT_READ, $urandom, 1'($urandom_range(0, 1)), size);
				sent++;
			end
		end
		steady = 1'b0;

		drain();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#3_200_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
